@@ rtl/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// cts_pkg
// Types and constants shared by the cooperative task scheduler table.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

   localparam int SLOTS       = 8;
   localparam int MAX_RESULTS = 8;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(SLOTS + 1);
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int TASK_W      = 8;
   localparam int TIME_W      = 16;
   localparam int PEND_W      = 8;
   localparam int OUT_SLOT_W  = 3;
   localparam int REQ_SLOT_W  = 3;

   localparam logic [PEND_W-1:0] PENDING_MAX = '1;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_ADD      = 2'd1,
      OP_DELETE   = 2'd2,
      OP_DISPATCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [TASK_W-1:0] tid;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] period;
      logic [PEND_W-1:0] pending;
   } entry_type;

   typedef struct packed {
      logic [TASK_W-1:0]     run_task;
      logic                  run_valid;
      logic [OUT_SLOT_W-1:0] out_slot;
      logic                  status;
      logic                  last;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/cts_mem.sv @@
// ----------------------------------------------------------------------------
// cts_mem
// Slot table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_mem (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [cts_pkg::SLOT_W-1:0]   wr_addr,
   input  cts_pkg::entry_type           wr_data,
   input  wire                          rd_en,
   input  wire  [cts_pkg::SLOT_W-1:0]   rd_addr,
   output cts_pkg::entry_type           rd_data
);
   import cts_pkg::*;

   entry_type mem_ff [SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/cts_rsp_reg.sv @@
// ----------------------------------------------------------------------------
// cts_rsp_reg
// Output register for result items; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_rsp_reg (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  cts_pkg::result_type  in_data,
   output logic                 out_valid,
   input  wire                  out_ready,
   output cts_pkg::result_type  out_data
);
   import cts_pkg::*;

   logic       full_ff;
   result_type data_ff;

   assign in_ready  = !full_ff || out_ready;
   assign out_valid = full_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         full_ff <= 1'b1;
      end else if (out_ready) begin
         full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/cooperative_task_scheduler_table_top.sv @@
// ----------------------------------------------------------------------------
// cooperative_task_scheduler_table_top
// Time-triggered cooperative scheduler: table of task slots with tick, add,
// delete and dispatch operations.
//
// Usage:
//   Request channel (req_*): one operation per item. Tick counts down every
//   occupied slot, add fills the first free slot, delete clears a slot,
//   dispatch emits every task with pending runs in slot order.
//   Result channel (rsp_*): one item for tick, add and delete; one item per
//   dispatched task for dispatch (at most 8), or one empty item when none
//   is ready. rsp_last marks the final item of each request.
//   Timing: the slot table sits in a single-port-read memory and is walked
//   one slot per cycle unless a dispatch walk stalls, read and write-back
//   overlapped; add and delete skip the walk. One request is in work at a
//   time; req_ready is high between requests. Results leave through an
//   output register, so the walk continues while one item waits. A stalled
//   receiver pauses a dispatch walk only when a result is found while an
//   earlier one is held and the register is still full.
//   Reset: synchronous, clears every slot (per-slot occupied bits) and all
//   control state; the block takes a request in the first cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module cooperative_task_scheduler_table_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [1:0]                         req_operation,
   input  wire  [cts_pkg::TASK_W-1:0]         req_task_id,
   input  wire  [cts_pkg::TIME_W-1:0]         req_start_delay,
   input  wire  [cts_pkg::TIME_W-1:0]         req_repeat_period,
   input  wire  [cts_pkg::REQ_SLOT_W-1:0]     req_slot,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [cts_pkg::TASK_W-1:0]         rsp_run_task,
   output logic                               rsp_run_valid,
   output logic [cts_pkg::OUT_SLOT_W-1:0]     rsp_out_slot,
   output logic                               rsp_status,
   output logic                               rsp_last
);
   import cts_pkg::*;

   state_type               state_ff, state_in;
   op_type                  op_ff;
   logic [TASK_W-1:0]       id_ff;
   logic [TIME_W-1:0]       dly_ff;
   logic [TIME_W-1:0]       per_ff;
   logic [REQ_SLOT_W-1:0]   sl_ff;
   logic                    latch_req;

   logic [CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    mod_valid_ff, mod_valid_in;
   logic [SLOT_W-1:0]       mod_idx_ff, mod_idx_in;
   logic                    rd_live_ff;
   logic [SLOTS-1:0]        live_ff, live_in;
   logic                    held_valid_ff, held_valid_in;
   logic [TASK_W-1:0]       held_task_ff, held_task_in;
   logic [SLOT_W-1:0]       held_slot_ff, held_slot_in;
   logic [RES_CNT_W-1:0]    count_ff, count_in;

   logic                    mem_we;
   logic [SLOT_W-1:0]       mem_waddr;
   entry_type               mem_wdata;
   logic                    mem_re;
   logic [SLOT_W-1:0]       mem_raddr;
   entry_type               mem_rdata;
   entry_type               cur;
   entry_type               upd;

   logic                    push_valid;
   logic                    push_ready;
   result_type              push_data;
   result_type              rsp_data;
   logic                    stall;
   logic                    issue;
   logic                    free_found;
   logic [SLOT_W-1:0]       free_idx;
   logic                    del_in_range;

   cts_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   cts_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_run_task  = rsp_data.run_task;
   assign rsp_run_valid = rsp_data.run_valid;
   assign rsp_out_slot  = rsp_data.out_slot;
   assign rsp_status    = rsp_data.status;
   assign rsp_last      = rsp_data.last;

   assign cur          = rd_live_ff ? mem_rdata : '0;
   assign del_in_range = int'(sl_ff) < SLOTS;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      mod_valid_in  = mod_valid_ff;
      mod_idx_in    = mod_idx_ff;
      live_in       = live_ff;
      held_valid_in = held_valid_ff;
      held_task_in  = held_task_ff;
      held_slot_in  = held_slot_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      mem_waddr     = mod_idx_ff;
      mem_wdata     = cur;
      mem_re        = 1'b0;
      mem_raddr     = rd_idx_ff[SLOT_W-1:0];
      push_valid    = 1'b0;
      push_data     = '0;
      req_ready     = 1'b0;
      latch_req     = 1'b0;
      upd           = cur;
      stall         = 1'b0;
      issue         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               latch_req     = 1'b1;
               rd_idx_in     = '0;
               mod_valid_in  = 1'b0;
               held_valid_in = 1'b0;
               count_in      = '0;
               if (op_type'(req_operation) == OP_TICK ||
                   op_type'(req_operation) == OP_DISPATCH) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end

         ST_WALK: begin
            if (mod_valid_ff) begin
               if (op_ff == OP_TICK) begin
                  if (cur.tid != '0) begin
                     if (cur.delay == '0) begin
                        if (cur.pending != PENDING_MAX) begin
                           upd.pending = cur.pending + 1'b1;
                        end
                        if (cur.period != '0) begin
                           upd.delay = cur.period;
                        end
                     end else begin
                        upd.delay = cur.delay - 1'b1;
                     end
                     mem_we    = 1'b1;
                     mem_wdata = upd;
                  end
               end else if (cur.pending != '0 &&
                            count_ff < RES_CNT_W'(MAX_RESULTS)) begin
                  if (held_valid_ff && !push_ready) begin
                     stall = 1'b1;
                  end else begin
                     push_valid          = held_valid_ff;
                     push_data.run_task  = held_task_ff;
                     push_data.run_valid = 1'b1;
                     push_data.out_slot  = OUT_SLOT_W'(held_slot_ff);
                     held_valid_in       = 1'b1;
                     held_task_in        = cur.tid;
                     held_slot_in        = mod_idx_ff;
                     count_in            = count_ff + 1'b1;
                     upd.pending         = cur.pending - 1'b1;
                     if (cur.period == '0) begin
                        upd                 = '0;
                        live_in[mod_idx_ff] = 1'b0;
                     end
                     mem_we    = 1'b1;
                     mem_wdata = upd;
                  end
               end
            end

            issue = !stall && rd_idx_ff < CNT_W'(SLOTS) &&
                    count_ff < RES_CNT_W'(MAX_RESULTS);
            if (!stall) begin
               mod_valid_in = issue;
               if (issue) begin
                  mem_re     = 1'b1;
                  mod_idx_in = rd_idx_ff[SLOT_W-1:0];
                  rd_idx_in  = rd_idx_ff + 1'b1;
               end
               if (!issue && !mod_valid_ff) begin
                  state_in = ST_FINAL;
               end
            end
         end

         ST_FINAL: begin
            push_valid     = 1'b1;
            push_data.last = 1'b1;
            case (op_ff)
               OP_ADD: begin
                  if (id_ff != '0) begin
                     if (free_found) begin
                        push_data.out_slot = OUT_SLOT_W'(free_idx);
                     end else begin
                        push_data.status = 1'b1;
                     end
                  end
               end
               OP_DELETE: begin
                  push_data.out_slot = OUT_SLOT_W'(sl_ff);
               end
               OP_DISPATCH: begin
                  if (held_valid_ff) begin
                     push_data.run_task  = held_task_ff;
                     push_data.run_valid = 1'b1;
                     push_data.out_slot  = OUT_SLOT_W'(held_slot_ff);
                  end
               end
               default: begin
               end
            endcase
            if (push_ready) begin
               state_in = ST_IDLE;
               if (op_ff == OP_ADD && id_ff != '0 && free_found) begin
                  mem_we            = 1'b1;
                  mem_waddr         = free_idx;
                  mem_wdata.tid     = id_ff;
                  mem_wdata.delay   = dly_ff;
                  mem_wdata.period  = per_ff;
                  mem_wdata.pending = '0;
                  live_in[free_idx] = 1'b1;
               end
               if (op_ff == OP_DELETE && del_in_range) begin
                  live_in[SLOT_W'(sl_ff)] = 1'b0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_idx_ff     <= '0;
         mod_valid_ff  <= 1'b0;
         live_ff       <= '0;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         mod_valid_ff  <= mod_valid_in;
         live_ff       <= live_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_idx_ff   <= mod_idx_in;
      held_task_ff <= held_task_in;
      held_slot_ff <= held_slot_in;
      if (mem_re) begin
         rd_live_ff <= live_ff[mem_raddr];
      end
      if (latch_req) begin
         op_ff  <= op_type'(req_operation);
         id_ff  <= req_task_id;
         dly_ff <= req_start_delay;
         per_ff <= req_repeat_period;
         sl_ff  <= req_slot;
      end
   end

   a_mod_in_walk: assert property (@(posedge clock) disable iff (reset)
      mod_valid_ff |-> state_ff == ST_WALK)
      else $error("slot in modify stage outside of a walk");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RES_CNT_W'(MAX_RESULTS))
      else $error("dispatch result count beyond limit");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff != ST_IDLE)
      else $error("accepted item did not start work");

   a_walk_not_last: assert property (@(posedge clock) disable iff (reset)
      (push_valid && state_ff == ST_WALK) |-> !push_data.last)
      else $error("final item flagged before walk ended");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cooperative task scheduler table. A driver
// feeds tick, add, delete and dispatch items from a backlog with random
// gaps. A shadow copy of the slot table predicts the result items of every
// accepted item. A monitor with random stalls checks each result against
// the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cts_pkg::*;

   typedef struct {
      op_type                op;
      logic [TASK_W-1:0]     task_id;
      logic [TIME_W-1:0]     start_delay;
      logic [TIME_W-1:0]     repeat_period;
      logic [REQ_SLOT_W-1:0] slot;
   } sched_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   wire                   req_ready;
   logic [1:0]            req_operation = OP_TICK;
   logic [TASK_W-1:0]     req_task_id = '0;
   logic [TIME_W-1:0]     req_start_delay = '0;
   logic [TIME_W-1:0]     req_repeat_period = '0;
   logic [REQ_SLOT_W-1:0] req_slot = '0;
   wire                   rsp_valid;
   logic                  rsp_ready = 1'b0;
   wire [TASK_W-1:0]      rsp_run_task;
   wire                   rsp_run_valid;
   wire [OUT_SLOT_W-1:0]  rsp_out_slot;
   wire                   rsp_status;
   wire                   rsp_last;

   sched_req_type req_backlog[$];
   sched_req_type cur_req;
   result_type    run_expect[$];
   entry_type     shadow_table[SLOTS] = '{default: '0};

   int mismatch_count = 0;
   int req_idle_left = 0;
   int req_calm = 0;
   int rsp_stall_left = 0;
   int rsp_calm = 0;

   cooperative_task_scheduler_table_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_task_id       (req_task_id),
      .req_start_delay   (req_start_delay),
      .req_repeat_period (req_repeat_period),
      .req_slot          (req_slot),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_run_task      (rsp_run_task),
      .rsp_run_valid     (rsp_run_valid),
      .rsp_out_slot      (rsp_out_slot),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int draw_pause(inout int calm);
      if (calm > 0) begin
         calm = calm - 1;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(5, 20);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic void clear_shadow_slot(input int idx);
      shadow_table[idx] = '0;
   endfunction

   // Advance the shadow table by one item and queue the results it causes.
   function automatic void schedule_update(input sched_req_type rq);
      result_type res;
      int         i;
      int         free_idx;
      int         emitted;
      res = '0;
      res.last = 1'b1;
      case (rq.op)
         OP_TICK: begin
            for (i = 0; i < SLOTS; i++) begin
               if (shadow_table[i].tid != '0) begin
                  if (shadow_table[i].delay == '0) begin
                     if (shadow_table[i].pending != PENDING_MAX)
                        shadow_table[i].pending = shadow_table[i].pending + 1'b1;
                     if (shadow_table[i].period != '0)
                        shadow_table[i].delay = shadow_table[i].period;
                  end else begin
                     shadow_table[i].delay = shadow_table[i].delay - 1'b1;
                  end
               end
            end
            run_expect.push_back(res);
         end
         OP_ADD: begin
            if (rq.task_id != '0) begin
               free_idx = -1;
               for (i = SLOTS - 1; i >= 0; i--)
                  if (shadow_table[i].tid == '0) free_idx = i;
               if (free_idx < 0) begin
                  res.status = 1'b1;
               end else begin
                  shadow_table[free_idx].tid     = rq.task_id;
                  shadow_table[free_idx].delay   = rq.start_delay;
                  shadow_table[free_idx].period  = rq.repeat_period;
                  shadow_table[free_idx].pending = '0;
                  res.out_slot = free_idx[OUT_SLOT_W-1:0];
               end
            end
            run_expect.push_back(res);
         end
         OP_DELETE: begin
            if (int'(rq.slot) < SLOTS) clear_shadow_slot(int'(rq.slot));
            res.out_slot = rq.slot;
            run_expect.push_back(res);
         end
         default: begin
            emitted = 0;
            for (i = 0; i < SLOTS && emitted < MAX_RESULTS; i++) begin
               if (shadow_table[i].pending != '0) begin
                  res.run_task  = shadow_table[i].tid;
                  res.run_valid = 1'b1;
                  res.out_slot  = i[OUT_SLOT_W-1:0];
                  res.status    = 1'b0;
                  res.last      = 1'b0;
                  run_expect.push_back(res);
                  emitted++;
                  shadow_table[i].pending = shadow_table[i].pending - 1'b1;
                  if (shadow_table[i].period == '0) clear_shadow_slot(i);
               end
            end
            if (emitted == 0) begin
               res = '0;
               res.last = 1'b1;
               run_expect.push_back(res);
            end else begin
               run_expect[run_expect.size() - 1].last = 1'b1;
            end
         end
      endcase
   endfunction

   function automatic void report_mismatch(input string what, input result_type want,
                                           input result_type seen);
      string exp_s;
      string got_s;
      mismatch_count++;
      if (mismatch_count <= 10) begin
         exp_s = $sformatf("task %0d valid %0d slot %0d status %0d last %0d",
                           want.run_task, want.run_valid, want.out_slot, want.status,
                           want.last);
         got_s = $sformatf("task %0d valid %0d slot %0d status %0d last %0d",
                           seen.run_task, seen.run_valid, seen.out_slot, seen.status,
                           seen.last);
         $display("%s: expected %s, got %s", what, exp_s, got_s);
      end
   endfunction

   // Driver: hold the item until accepted, then wait the drawn gap.
   always @(posedge clock) begin
      sched_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_idle_left <= 0;
      end else begin
         if (req_valid && req_ready) schedule_update(cur_req);
         if (!req_valid || req_ready) begin
            if (req_idle_left != 0) begin
               req_idle_left <= req_idle_left - 1;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               nxt = req_backlog.pop_front();
               cur_req           <= nxt;
               req_operation     <= nxt.op;
               req_task_id       <= nxt.task_id;
               req_start_delay   <= nxt.start_delay;
               req_repeat_period <= nxt.repeat_period;
               req_slot          <= nxt.slot;
               req_valid         <= 1'b1;
               req_idle_left     <= draw_pause(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result, then stall for the drawn count.
   always @(posedge clock) begin
      int         hold;
      result_type seen;
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_left <= 0;
      end else begin
         hold = rsp_stall_left;
         if (rsp_valid && rsp_ready) begin
            seen.run_task  = rsp_run_task;
            seen.run_valid = rsp_run_valid;
            seen.out_slot  = rsp_out_slot;
            seen.status    = rsp_status;
            seen.last      = rsp_last;
            if (run_expect.size() == 0) begin
               report_mismatch("unexpected result", '0, seen);
            end else begin
               want = run_expect.pop_front();
               if (seen !== want) report_mismatch("mismatch", want, seen);
            end
            hold = draw_pause(rsp_calm);
         end
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left <= hold - 1;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall_left <= 0;
         end
      end
   end

   task automatic push_req(input op_type op, input logic [TASK_W-1:0] id,
                           input logic [TIME_W-1:0] dly, input logic [TIME_W-1:0] per,
                           input logic [REQ_SLOT_W-1:0] sl);
      sched_req_type rq;
      rq.op            = op;
      rq.task_id       = id;
      rq.start_delay   = dly;
      rq.repeat_period = per;
      rq.slot          = sl;
      req_backlog.push_back(rq);
   endtask

   initial begin
      op_type                op;
      logic [TASK_W-1:0]     id;
      logic [TIME_W-1:0]     dly;
      logic [TIME_W-1:0]     per;
      logic [REQ_SLOT_W-1:0] sl;
      int                    n;
      int                    pick;
      bit                    noise;

      // directed: empty table, ignored add, full table, all eight ready
      push_req(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);
      push_req(OP_TICK,     8'h00, 16'h0000, 16'h0000, 3'd0);
      push_req(OP_ADD,      8'h00, 16'h0005, 16'h0003, 3'd0);
      push_req(OP_ADD,      8'hFF, 16'h0000, 16'h0000, 3'd7);
      push_req(OP_ADD,      8'h01, 16'h0000, 16'hFFFF, 3'd0);
      push_req(OP_ADD,      8'h80, 16'h0000, 16'h0001, 3'd0);
      push_req(OP_ADD,      8'hAA, 16'h0000, 16'h0002, 3'd0);
      push_req(OP_ADD,      8'h55, 16'h0000, 16'h0000, 3'd0);
      push_req(OP_ADD,      8'h7F, 16'h0000, 16'h0003, 3'd0);
      push_req(OP_ADD,      8'hFE, 16'h0000, 16'h0001, 3'd0);
      push_req(OP_ADD,      8'h02, 16'h0000, 16'hFFFF, 3'd0);
      push_req(OP_ADD,      8'h42, 16'h0001, 16'h0001, 3'd0);
      push_req(OP_TICK,     8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
      push_req(OP_DISPATCH, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
      push_req(OP_TICK,     8'h00, 16'h0000, 16'h0000, 3'd0);
      push_req(OP_TICK,     8'h00, 16'h0000, 16'h0000, 3'd0);
      push_req(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);
      push_req(OP_DELETE,   8'h00, 16'h0000, 16'h0000, 3'd0);
      push_req(OP_DELETE,   8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
      push_req(OP_ADD,      8'h33, 16'hFFFF, 16'hFFFF, 3'd0);
      push_req(OP_ADD,      8'h34, 16'h0000, 16'h0000, 3'd0);
      push_req(OP_TICK,     8'h00, 16'h0000, 16'h0000, 3'd0);
      push_req(OP_TICK,     8'h00, 16'h0000, 16'h0000, 3'd0);
      push_req(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);

      // clear the table, build up several runs on one task, then drain them
      for (n = 0; n < SLOTS; n++) push_req(OP_DELETE, 8'h00, 16'h0000, 16'h0000, n[2:0]);
      push_req(OP_ADD, 8'h99, 16'h0000, 16'h0001, 3'd0);
      for (n = 0; n < 6; n++) push_req(OP_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
      for (n = 0; n < 4; n++) push_req(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);

      // random: mostly short delays so tasks come due, some full-range noise
      for (n = 0; n < 57; n++) begin
         pick  = $urandom_range(0, 99);
         noise = ($urandom_range(0, 9) == 0);
         if (noise) id = 8'($urandom_range(0, 255));
         else id = ($urandom_range(0, 11) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
         dly = (noise || $urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 4));
         per = (noise || $urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 4));
         sl  = 3'($urandom_range(0, 7));
         if (pick < 35) op = OP_TICK;
         else if (pick < 60) op = OP_ADD;
         else if (pick < 75) op = OP_DELETE;
         else op = OP_DISPATCH;
         push_req(op, id, dly, per, sl);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || run_expect.size() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);

      if (mismatch_count == 0 && run_expect.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
